### rtl/core/http_request_completeness_check_unit_defines.svh
// assertion macros for the http request completeness check unit
// no dependencies; included by hrcc_back, the one module that asserts
`ifndef HTTP_REQUEST_COMPLETENESS_CHECK_UNIT_DEFINES_SVH
`define HTTP_REQUEST_COMPLETENESS_CHECK_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HRCC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrcc check failed");

// next-cycle implication, disabled during reset
`define HRCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrcc check failed");

`endif

### rtl/core/hrcc_pkg.sv
// shared types and constants of the http request completeness check unit
// no dependencies
package hrcc_pkg;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // framing mode codes
   localparam logic [1:0] FM_NONE    = 2'd0;
   localparam logic [1:0] FM_LENGTH  = 2'd1;
   localparam logic [1:0] FM_CHUNKED = 2'd2;

   // key lengths, full tail fill level and terminator done code
   localparam logic [3:0] LEN_KEY_LEN = 4'd15;
   localparam logic [2:0] CHK_KEY_LEN = 3'd7;
   localparam logic [2:0] TAIL_FULL   = 3'd5;
   localparam logic [2:0] TERM_DONE   = 3'd4;

   // characters
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_UP_C  = 8'h43;
   localparam logic [7:0] CH_LO_C  = 8'h63;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SKIP,
      PH_SPACE,
      PH_PLUS,
      PH_MINUS,
      PH_DIGITS,
      PH_NEG_DIGITS,
      PH_DONE
   } phase_type;

   // one classified byte as it sits in the queue
   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       is_space;
      logic       is_digit;
      logic [3:0] digit;
   } item_type;

   function automatic logic [7:0] len_key_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = "C";
         4'd1:    c = "o";
         4'd2:    c = "n";
         4'd3:    c = "t";
         4'd4:    c = "e";
         4'd5:    c = "n";
         4'd6:    c = "t";
         4'd7:    c = "-";
         4'd8:    c = "L";
         4'd9:    c = "e";
         4'd10:   c = "n";
         4'd11:   c = "g";
         4'd12:   c = "t";
         4'd13:   c = "h";
         4'd14:   c = ":";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] chk_key_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = "c";
         3'd1:    c = "h";
         3'd2:    c = "u";
         3'd3:    c = "n";
         3'd4:    c = "k";
         3'd5:    c = "e";
         3'd6:    c = "d";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### rtl/core/http_request_completeness_check_unit.sv
// an accepted byte goes into the queue, then its result into the result register
// throughput: one byte per cycle unless results stall, set by the back part's state update
// the 4-entry queue lets the front keep accepting while the result side stalls, until it fills
// reset: synchronous, active high; clears queue pointers, framing state and result valid
// a byte with first_of_request set starts a new request from the cleared state
// top level: front classifier and queue, back framing state machine and result register
module http_request_completeness_check_unit #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request byte channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_request,
   // result channel, one word per request byte
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_headers_received,
   output logic [31:0] rsp_body_bytes,
   output logic [1:0]  rsp_framing_mode,
   output logic        rsp_request_valid
);

   // queue link between front and back
   logic               q_valid;
   logic               q_ready;
   hrcc_pkg::item_type q_item;

   // front: byte classification (space, digit, digit value) and queue
   hrcc_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_first_of_request (req_first_of_request),
      .q_valid              (q_valid),
      .q_ready              (q_ready),
      .q_item               (q_item)
   );

   // back: key matchers, length parser, body counter, tail check, verdict
   hrcc_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_ready              (q_ready),
      .q_item               (q_item),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_headers_received (rsp_headers_received),
      .rsp_body_bytes       (rsp_body_bytes),
      .rsp_framing_mode     (rsp_framing_mode),
      .rsp_request_valid    (rsp_request_valid)
   );

endmodule

### rtl/core/hrcc_front.sv
// front part: accepts request bytes, classifies them, queues them for the back
// depends on hrcc_pkg
module hrcc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_first_of_request,
   output logic               q_valid,
   input  logic               q_ready,
   output hrcc_pkg::item_type q_item
);

   hrcc_pkg::item_type                   mem_ff [hrcc_pkg::QUEUE_DEPTH];
   logic [hrcc_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [hrcc_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [hrcc_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   hrcc_pkg::item_type                   cls;
   logic                                 push, pop;

   // byte classification
   always_comb begin
      cls.data     = req_data_byte;
      cls.first    = req_first_of_request;
      cls.is_space = (req_data_byte == 8'd32) ||
                     (req_data_byte >= 8'd9 && req_data_byte <= 8'd13);
      cls.is_digit = (req_data_byte >= 8'h30) && (req_data_byte <= 8'h39);
      cls.digit    = 4'(req_data_byte - 8'h30);
   end

   assign req_ready = (count_ff != hrcc_pkg::QUEUE_CNT_W'(hrcc_pkg::QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### rtl/core/hrcc_back.sv
// back part: per-request framing state, verdict and result register
// depends on hrcc_pkg and the assertion macro header
`include "http_request_completeness_check_unit_defines.svh"

module hrcc_back #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  hrcc_pkg::item_type q_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_headers_received,
   output logic [31:0]        rsp_body_bytes,
   output logic [1:0]         rsp_framing_mode,
   output logic               rsp_request_valid
);

   // framing state
   logic                      in_body_ff, in_body_in;
   logic [2:0]                term_ff, term_in;
   logic [3:0]                lkey_ff, lkey_in;
   logic                      lfound_ff, lfound_in;
   hrcc_pkg::phase_type       phase_ff, phase_in;
   logic [31:0]               lvalue_ff, lvalue_in;
   logic                      lbad_ff, lbad_in;
   logic [2:0]                ckey_ff, ckey_in;
   logic                      cfound_ff, cfound_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [39:0]               tail_ff, tail_in;
   logic [2:0]                fill_ff, fill_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      hdr_ff;
   logic [31:0]               body_ff;
   logic [1:0]                mode_ff;
   logic                      verdict_ff;
   logic                      hdr_in;
   logic [31:0]               body_in;
   logic [1:0]                mode_in;
   logic                      verdict_in;

   logic                      pop;

   assign q_ready = !rsp_valid_ff || rsp_ready;
   assign pop     = q_valid && q_ready;

   always_comb begin
      logic                   c_in_body;
      logic [2:0]             c_term;
      logic [3:0]             c_lkey;
      logic                   c_lfound;
      hrcc_pkg::phase_type    c_phase;
      logic [31:0]            c_lvalue;
      logic                   c_lbad;
      logic [2:0]             c_ckey;
      logic                   c_cfound;
      logic [COUNT_WIDTH-1:0] c_count;
      logic [39:0]            c_tail;
      logic [2:0]             c_fill;
      logic [7:0]             b;
      logic                   neg;
      logic                   run_digit;
      logic [35:0]            v;
      logic [2:0]             zeros;
      logic                   tail_chars_ok;
      logic [7:0]             tb;
      logic [63:0]            count_ext;

      // a new request starts from the reset state
      c_in_body = q_item.first ? 1'b0 : in_body_ff;
      c_term    = q_item.first ? 3'd0 : term_ff;
      c_lkey    = q_item.first ? 4'd0 : lkey_ff;
      c_lfound  = q_item.first ? 1'b0 : lfound_ff;
      c_phase   = q_item.first ? hrcc_pkg::PH_IDLE : phase_ff;
      c_lvalue  = q_item.first ? 32'd0 : lvalue_ff;
      c_lbad    = q_item.first ? 1'b0 : lbad_ff;
      c_ckey    = q_item.first ? 3'd0 : ckey_ff;
      c_cfound  = q_item.first ? 1'b0 : cfound_ff;
      c_count   = q_item.first ? '0 : count_ff;
      c_tail    = q_item.first ? 40'd0 : tail_ff;
      c_fill    = q_item.first ? 3'd0 : fill_ff;
      b         = q_item.data;

      in_body_in = c_in_body;
      term_in    = c_term;
      lkey_in    = c_lkey;
      lfound_in  = c_lfound;
      phase_in   = c_phase;
      lvalue_in  = c_lvalue;
      lbad_in    = c_lbad;
      ckey_in    = c_ckey;
      cfound_in  = c_cfound;
      count_in   = c_count;
      tail_in    = c_tail;
      fill_in    = c_fill;

      neg       = (c_phase == hrcc_pkg::PH_MINUS) || (c_phase == hrcc_pkg::PH_NEG_DIGITS);
      run_digit = 1'b0;
      v         = ({4'd0, c_lvalue} << 3) + ({4'd0, c_lvalue} << 1) + 36'(q_item.digit);

      if (!c_in_body) begin
         // length value parser
         unique case (c_phase)
            hrcc_pkg::PH_SKIP: begin
               phase_in = hrcc_pkg::PH_SPACE;
            end
            hrcc_pkg::PH_SPACE: begin
               if (q_item.is_space) begin
                  phase_in = c_phase;
               end else if (b == hrcc_pkg::CH_PLUS) begin
                  phase_in = hrcc_pkg::PH_PLUS;
               end else if (b == hrcc_pkg::CH_MINUS) begin
                  phase_in = hrcc_pkg::PH_MINUS;
               end else begin
                  run_digit = 1'b1;
               end
            end
            hrcc_pkg::PH_PLUS, hrcc_pkg::PH_MINUS,
            hrcc_pkg::PH_DIGITS, hrcc_pkg::PH_NEG_DIGITS: begin
               run_digit = 1'b1;
            end
            default: begin
               phase_in = c_phase;
            end
         endcase
         if (run_digit) begin
            if (q_item.is_digit) begin
               if (neg && q_item.digit != 4'd0) begin
                  lbad_in = 1'b1;
               end
               if (v[35:32] != 4'd0) begin
                  lbad_in  = 1'b1;
                  phase_in = hrcc_pkg::PH_DONE;
               end else begin
                  lvalue_in = v[31:0];
                  phase_in  = neg ? hrcc_pkg::PH_NEG_DIGITS : hrcc_pkg::PH_DIGITS;
               end
            end else begin
               phase_in = hrcc_pkg::PH_DONE;
            end
         end

         // content-length key matcher
         if (!c_lfound) begin
            if (c_lkey != hrcc_pkg::LEN_KEY_LEN && hrcc_pkg::len_key_char(c_lkey) == b) begin
               lkey_in = c_lkey + 4'd1;
            end else begin
               lkey_in = (b == hrcc_pkg::CH_UP_C) ? 4'd1 : 4'd0;
            end
            if (lkey_in == hrcc_pkg::LEN_KEY_LEN) begin
               lfound_in = 1'b1;
               phase_in  = hrcc_pkg::PH_SKIP;
            end
         end

         // chunked key matcher
         if (!c_cfound) begin
            if (c_ckey != hrcc_pkg::CHK_KEY_LEN && hrcc_pkg::chk_key_char(c_ckey) == b) begin
               ckey_in = c_ckey + 3'd1;
            end else begin
               ckey_in = (b == hrcc_pkg::CH_LO_C) ? 3'd1 : 3'd0;
            end
            if (ckey_in == hrcc_pkg::CHK_KEY_LEN) begin
               cfound_in = 1'b1;
            end
         end

         // header terminator
         if (b == hrcc_pkg::CH_CR) begin
            term_in = (c_term == 3'd2) ? 3'd3 : 3'd1;
         end else if (b == hrcc_pkg::CH_LF) begin
            if (c_term == 3'd1) begin
               term_in = 3'd2;
            end else if (c_term == 3'd3) begin
               term_in    = hrcc_pkg::TERM_DONE;
               in_body_in = 1'b1;
            end else begin
               term_in = 3'd0;
            end
         end else begin
            term_in = 3'd0;
         end
      end else begin
         if (c_count != '1) begin
            count_in = c_count + COUNT_WIDTH'(1);
         end
         tail_in = {c_tail[31:0], b};
         if (c_fill != hrcc_pkg::TAIL_FULL) begin
            fill_in = c_fill + 3'd1;
         end
      end

      // chunked tail check over the last five body bytes
      zeros         = 3'd0;
      tail_chars_ok = 1'b1;
      for (int i = 0; i < 5; i++) begin
         tb = tail_in[8*i +: 8];
         if (tb == hrcc_pkg::CH_ZERO) begin
            zeros = zeros + 3'd1;
         end else if (tb != hrcc_pkg::CH_CR && tb != hrcc_pkg::CH_LF) begin
            tail_chars_ok = 1'b0;
         end
      end

      count_ext = 64'(count_in);
      hdr_in    = in_body_in;
      body_in   = (count_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : count_ext[31:0];
      if (lfound_in) begin
         mode_in    = hrcc_pkg::FM_LENGTH;
         verdict_in = !lbad_in && (64'(lvalue_in) == count_ext);
      end else if (cfound_in) begin
         mode_in    = hrcc_pkg::FM_CHUNKED;
         verdict_in = (fill_in == hrcc_pkg::TAIL_FULL) && tail_chars_ok && (zeros == 3'd1);
      end else begin
         mode_in    = hrcc_pkg::FM_NONE;
         verdict_in = 1'b1;
      end
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff   <= 1'b0;
         term_ff      <= 3'd0;
         lkey_ff      <= 4'd0;
         lfound_ff    <= 1'b0;
         phase_ff     <= hrcc_pkg::PH_IDLE;
         lvalue_ff    <= 32'd0;
         lbad_ff      <= 1'b0;
         ckey_ff      <= 3'd0;
         cfound_ff    <= 1'b0;
         count_ff     <= '0;
         tail_ff      <= 40'd0;
         fill_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            in_body_ff <= in_body_in;
            term_ff    <= term_in;
            lkey_ff    <= lkey_in;
            lfound_ff  <= lfound_in;
            phase_ff   <= phase_in;
            lvalue_ff  <= lvalue_in;
            lbad_ff    <= lbad_in;
            ckey_ff    <= ckey_in;
            cfound_ff  <= cfound_in;
            count_ff   <= count_in;
            tail_ff    <= tail_in;
            fill_ff    <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         hdr_ff     <= hdr_in;
         body_ff    <= body_in;
         mode_ff    <= mode_in;
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_headers_received = hdr_ff;
   assign rsp_body_bytes       = body_ff;
   assign rsp_framing_mode     = mode_ff;
   assign rsp_request_valid    = verdict_ff;

   `HRCC_ASSERT_NOW(a_body_after_term, clock, reset, in_body_ff, term_ff == hrcc_pkg::TERM_DONE)
   `HRCC_ASSERT_NOW(a_parser_armed, clock, reset, lfound_ff, phase_ff != hrcc_pkg::PH_IDLE)
   `HRCC_ASSERT_NOW(a_fill_tracks_count, clock, reset, fill_ff != hrcc_pkg::TAIL_FULL, count_ff == COUNT_WIDTH'(fill_ff))
   `HRCC_ASSERT_NOW(a_no_body_in_header, clock, reset, rsp_valid_ff && !hdr_ff, body_ff == 32'd0)

endmodule

### dv/http_request_completeness_check_unit_tb.sv
// testbench of http_request_completeness_check_unit: random and directed http request streams
// checked word by word against an in-bench framing predictor; depends on hrcc_pkg and the rtl
module http_request_completeness_check_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_W        = 32;
   localparam int TOTAL_WORDS    = 1400;
   localparam int SEG_WORDS      = 180;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int PRESSURE_PHASE = 4;
   localparam int NUM_PHASES     = 5;

   // header keys, first character in the top byte
   localparam logic [8*15-1:0] LENGTH_KEY  = "Content-Length:";
   localparam logic [8*7-1:0]  CHUNKED_KEY = "chunked";

   typedef struct packed {
      logic [7:0] data;
      logic       first;
   } req_byte_type;

   typedef struct packed {
      logic        headers_received;
      logic [31:0] body_bytes;
      logic [1:0]  framing_mode;
      logic        request_valid;
   } framing_verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_of_request = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_headers_received;
   logic [31:0] rsp_body_bytes;
   logic [1:0]  rsp_framing_mode;
   logic        rsp_request_valid;

   http_request_completeness_check_unit #(
      .COUNT_WIDTH(COUNT_W)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_first_of_request (req_first_of_request),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_headers_received (rsp_headers_received),
      .rsp_body_bytes       (rsp_body_bytes),
      .rsp_framing_mode     (rsp_framing_mode),
      .rsp_request_valid    (rsp_request_valid)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   req_byte_type        pending_bytes[$];
   framing_verdict_type expected_verdicts[$];

   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int total_words = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_armed = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   // ---------------------------------------------------------------
   // framing predictor state
   // ---------------------------------------------------------------
   bit                  hdr_done;
   logic [2:0]          term_prog;
   logic [3:0]          len_prog;
   bit                  len_found;
   hrcc_pkg::phase_type len_phase;
   logic [31:0]         len_value;
   bit                  len_bad;
   logic [2:0]          chk_prog;
   bit                  chk_found;
   logic [COUNT_W-1:0]  body_cnt;
   logic [39:0]         tail;
   logic [2:0]          tail_fill;

   task automatic clear_framing();
      hdr_done  = 1'b0;
      term_prog = '0;
      len_prog  = '0;
      len_found = 1'b0;
      len_phase = hrcc_pkg::PH_IDLE;
      len_value = '0;
      len_bad   = 1'b0;
      chk_prog  = '0;
      chk_found = 1'b0;
      body_cnt  = '0;
      tail      = '0;
      tail_fill = '0;
   endtask

   function automatic bit is_ws(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   // chunked end: last five body bytes all cr, lf or '0', exactly one '0'
   function automatic bit tail_good();
      int zeros;
      logic [7:0] c;
      zeros = 0;
      if (tail_fill < hrcc_pkg::TAIL_FULL) return 1'b0;
      for (int i = 0; i < 5; i++) begin
         c = tail[8*i +: 8];
         if (c == hrcc_pkg::CH_ZERO) zeros++;
         else if (c != hrcc_pkg::CH_CR && c != hrcc_pkg::CH_LF) return 1'b0;
      end
      return zeros == 1;
   endfunction

   task automatic predict_framing(input logic [7:0] b, input logic first,
                                  output framing_verdict_type v);
      logic [63:0] acc;
      logic [3:0]  d;
      bit          neg;
      bit          digit_step;
      digit_step = 1'b0;
      if (first) clear_framing();
      if (!hdr_done) begin
         // value parse runs ahead of the key matchers on the same byte
         case (len_phase)
            hrcc_pkg::PH_SKIP: len_phase = hrcc_pkg::PH_SPACE;
            hrcc_pkg::PH_SPACE: begin
               if (is_ws(b)) ;
               else if (b == hrcc_pkg::CH_PLUS) len_phase = hrcc_pkg::PH_PLUS;
               else if (b == hrcc_pkg::CH_MINUS) len_phase = hrcc_pkg::PH_MINUS;
               else digit_step = 1'b1;
            end
            hrcc_pkg::PH_PLUS, hrcc_pkg::PH_MINUS,
            hrcc_pkg::PH_DIGITS, hrcc_pkg::PH_NEG_DIGITS: digit_step = 1'b1;
            default: ;
         endcase
         if (digit_step) begin
            if (b >= hrcc_pkg::CH_ZERO && b <= hrcc_pkg::CH_ZERO + 8'd9) begin
               neg = (len_phase == hrcc_pkg::PH_MINUS || len_phase == hrcc_pkg::PH_NEG_DIGITS);
               d   = 4'(b - hrcc_pkg::CH_ZERO);
               acc = 64'(len_value) * 64'd10 + 64'(d);
               if (neg && d != 4'd0) len_bad = 1'b1;
               if (acc > 64'hFFFF_FFFF) begin
                  len_bad   = 1'b1;
                  len_phase = hrcc_pkg::PH_DONE;
               end else begin
                  len_value = acc[31:0];
                  len_phase = neg ? hrcc_pkg::PH_NEG_DIGITS : hrcc_pkg::PH_DIGITS;
               end
            end else begin
               len_phase = hrcc_pkg::PH_DONE;
            end
         end
         // content-length key, restart only on 'C'
         if (!len_found) begin
            if (len_prog < hrcc_pkg::LEN_KEY_LEN &&
                LENGTH_KEY[8*(14 - len_prog) +: 8] == b) len_prog = len_prog + 4'd1;
            else len_prog = (b == hrcc_pkg::CH_UP_C) ? 4'd1 : 4'd0;
            if (len_prog == hrcc_pkg::LEN_KEY_LEN) begin
               len_found = 1'b1;
               len_phase = hrcc_pkg::PH_SKIP;
            end
         end
         // chunked key, restart only on 'c'
         if (!chk_found) begin
            if (chk_prog < hrcc_pkg::CHK_KEY_LEN &&
                CHUNKED_KEY[8*(6 - chk_prog) +: 8] == b) chk_prog = chk_prog + 3'd1;
            else chk_prog = (b == hrcc_pkg::CH_LO_C) ? 3'd1 : 3'd0;
            if (chk_prog == hrcc_pkg::CHK_KEY_LEN) chk_found = 1'b1;
         end
         // cr lf cr lf terminator
         if (b == hrcc_pkg::CH_CR) begin
            term_prog = (term_prog == 3'd2) ? 3'd3 : 3'd1;
         end else if (b == hrcc_pkg::CH_LF) begin
            if (term_prog == 3'd1) term_prog = 3'd2;
            else if (term_prog == 3'd3) begin
               term_prog = hrcc_pkg::TERM_DONE;
               hdr_done  = 1'b1;
            end else term_prog = 3'd0;
         end else begin
            term_prog = 3'd0;
         end
      end else begin
         if (body_cnt != '1) body_cnt = body_cnt + 1'b1;
         tail = {tail[31:0], b};
         if (tail_fill < hrcc_pkg::TAIL_FULL) tail_fill = tail_fill + 1'b1;
      end

      v.headers_received = hdr_done;
      v.body_bytes       = (64'(body_cnt) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(body_cnt);
      if (len_found) begin
         v.framing_mode  = hrcc_pkg::FM_LENGTH;
         v.request_valid = !len_bad && (64'(len_value) == 64'(body_cnt));
      end else if (chk_found) begin
         v.framing_mode  = hrcc_pkg::FM_CHUNKED;
         v.request_valid = tail_good();
      end else begin
         v.framing_mode  = hrcc_pkg::FM_NONE;
         v.request_valid = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------
   // stream builders
   // ---------------------------------------------------------------
   task automatic push_word(input logic [7:0] b, input logic first);
      req_byte_type w;
      w.data  = b;
      w.first = first;
      pending_bytes.insert(pending_bytes.size(), w);
   endtask

   task automatic push_text(input string s, input logic lead_first);
      for (int i = 0; i < s.len(); i++) push_word(s[i], (i == 0) ? lead_first : 1'b0);
   endtask

   task automatic push_crlf();
      push_word(hrcc_pkg::CH_CR, 1'b0);
      push_word(hrcc_pkg::CH_LF, 1'b0);
   endtask

   // mostly plain space, sometimes any of the other whitespace codes
   function automatic logic [7:0] pick_space();
      if ($urandom_range(3) != 0) return 8'h20;
      return 8'h09 + 8'($urandom_range(4));
   endfunction

   function automatic logic [7:0] pick_tail_byte();
      case ($urandom_range(2))
         0:       return hrcc_pkg::CH_CR;
         1:       return hrcc_pkg::CH_LF;
         default: return hrcc_pkg::CH_ZERO;
      endcase
   endfunction

   // body bytes lean on digits and line breaks, the rest anything
   function automatic logic [7:0] pick_body_byte();
      int r;
      r = $urandom_range(9);
      if (r < 3) return hrcc_pkg::CH_ZERO + 8'($urandom_range(9));
      if (r < 5) return pick_tail_byte();
      return 8'($urandom_range(255));
   endfunction

   task automatic push_length_line(output int target);
      string key;
      string val;
      int    v;
      case ($urandom_range(19))
         0:       key = "Content-Lengt:";
         1:       key = "CContent-Length:";
         2:       key = "content-length:";
         3:       key = "Content-Length";
         default: key = "Content-Length:";
      endcase
      push_text(key, 1'b0);
      // the one skipped character
      if ($urandom_range(4) != 0) push_word(8'h20, 1'b0);
      else push_word(8'($urandom_range(255)), 1'b0);
      repeat ($urandom_range(2)) push_word(pick_space(), 1'b0);
      target = -1;
      v = $urandom_range(12);
      case ($urandom_range(11))
         0, 1, 2, 3, 4, 5: begin
            val = $sformatf("%0d", v);
            target = v;
         end
         6: begin
            val = $sformatf("+%0d", v);
            target = v;
         end
         // negative zero is a plain zero
         7: begin
            val = $urandom_range(1) ? "-0" : "-00";
            target = 0;
         end
         8: val = $sformatf("-%0d", $urandom_range(1, 9));
         // top of the range, just past it, far past it, a random value or leading zeros
         9: begin
            case ($urandom_range(4))
               0: val = "4294967295";
               1: val = "4294967296";
               2: val = "99999999999";
               3: val = $sformatf("%0d", $urandom());
               default: begin
                  val = "0004";
                  target = 4;
               end
            endcase
         end
         // sign or nothing, no digits
         10: begin
            case ($urandom_range(2))
               0:       val = "";
               1:       val = "+";
               default: val = "-";
            endcase
            target = 0;
         end
         default: begin
            val = $sformatf("%0dx", v);
            target = v;
         end
      endcase
      push_text(val, 1'b0);
      push_crlf();
   endtask

   task automatic push_chunked_line();
      case ($urandom_range(7))
         0:       push_text("Transfer-Encoding: chunke", 1'b0);
         1:       push_text("Transfer-Encoding: chunkchunked", 1'b0);
         2:       push_text("Transfer-Encoding: gzip, chunked", 1'b0);
         default: push_text("Transfer-Encoding: chunked", 1'b0);
      endcase
      push_crlf();
   endtask

   task automatic push_request();
      string line;
      int    target;
      int    nbody;
      int    n;
      int    pick;
      bit    has_len;
      bit    has_chk;
      bit    len_first;
      target    = -1;
      has_len   = ($urandom_range(99) < 60);
      has_chk   = ($urandom_range(99) < 40);
      len_first = $urandom_range(1);
      case ($urandom_range(5))
         0, 1:    line = "GET / HTTP/1.1";
         2:       line = "POST /form HTTP/1.1";
         3:       line = "PUT /upload HTTP/1.1";
         default: line = ($urandom_range(3) == 0) ? "GET /chunked HTTP/1.1" : "GET /a HTTP/1.1";
      endcase
      // most requests start fresh, some run on from the previous one
      push_text(line, $urandom_range(9) != 0);
      push_crlf();
      repeat ($urandom_range(2)) begin
         push_text($sformatf("X-%c: %0d", 8'h61 + 8'($urandom_range(25)), $urandom_range(999)),
                   1'b0);
         push_crlf();
      end
      if (has_len && len_first) push_length_line(target);
      if (has_chk) push_chunked_line();
      if (has_len && !len_first) push_length_line(target);
      // blank line, a broken one, or none at all
      pick = $urandom_range(19);
      if (pick < 17) begin
         push_crlf();
      end else if (pick == 17) begin
         push_word(hrcc_pkg::CH_LF, 1'b0);
         push_crlf();
      end
      if (has_len) begin
         if (target >= 0) begin
            nbody = target + $urandom_range(2) - 1;
            if (nbody < 0) nbody = 0;
         end else begin
            nbody = $urandom_range(6);
         end
         repeat (nbody) push_word(pick_body_byte(), 1'b0);
      end else if (has_chk || $urandom_range(3) == 0) begin
         case ($urandom_range(3))
            0, 1: begin
               repeat ($urandom_range(2)) begin
                  n = $urandom_range(1, 6);
                  push_text($sformatf("%0h", n), 1'b0);
                  push_crlf();
                  repeat (n) push_word(pick_body_byte(), 1'b0);
                  push_crlf();
               end
               push_word(hrcc_pkg::CH_ZERO, 1'b0);
               push_crlf();
               push_crlf();
            end
            2:       repeat ($urandom_range(3, 8)) push_word(pick_tail_byte(), 1'b0);
            default: repeat ($urandom_range(6)) push_word(pick_body_byte(), 1'b0);
         endcase
      end else begin
         repeat ($urandom_range(5)) push_word(pick_body_byte(), 1'b0);
      end
      // stray bytes between requests
      if ($urandom_range(4) == 0)
         repeat ($urandom_range(1, 6)) push_word(8'($urandom_range(255)), $urandom_range(9) == 0);
   endtask

   // ---------------------------------------------------------------
   // driver: offers pending words, predicts each one as it is taken
   // ---------------------------------------------------------------
   req_byte_type        next_byte;
   framing_verdict_type predicted;

   always @(posedge clock) begin
      if (reset) begin
         clear_framing();
         req_valid            <= 1'b0;
         req_data_byte        <= 8'h00;
         req_first_of_request <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_framing(req_data_byte, req_first_of_request, predicted);
            expected_verdicts.insert(expected_verdicts.size(), predicted);
            words_in <= words_in + 1;
         end
         // a new word only once the last one is gone; valid stays up otherwise
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_byte = pending_bytes.pop_front();
               req_valid            <= 1'b1;
               req_data_byte        <= next_byte.data;
               req_first_of_request <= next_byte.first;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver hold-off: a long stretch with ready low, so the block fills
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_armed) begin
         hold_left <= HOLD_CYCLES;
         hold_seen <= hold_armed;
      end
   end

   // ---------------------------------------------------------------
   // monitor: takes result words and checks them against the oldest prediction
   // ---------------------------------------------------------------
   framing_verdict_type observed;
   framing_verdict_type wanted;

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed.headers_received = rsp_headers_received;
            observed.body_bytes       = rsp_body_bytes;
            observed.framing_mode     = rsp_framing_mode;
            observed.request_valid    = rsp_request_valid;
            words_out <= words_out + 1;
            if (expected_verdicts.size() == 0) begin
               $display("%0t result word with nothing expected: expected none, got %h",
                        $time, observed);
               errors++;
            end else begin
               wanted = expected_verdicts.pop_front();
               check_field("headers_received", 32'(wanted.headers_received),
                           32'(observed.headers_received));
               check_field("body_bytes", wanted.body_bytes, observed.body_bytes);
               check_field("framing_mode", 32'(wanted.framing_mode), 32'(observed.framing_mode));
               check_field("request_valid", 32'(wanted.request_valid),
                           32'(observed.request_valid));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // watchdog: too long with no word moving on either side
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t no word moved for %0d cycles", $time, idle_cycles);
         $display("[http_request_completeness_check_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // stimulus and run control
   // ---------------------------------------------------------------
   int send_pct_by_phase[NUM_PHASES] = '{0, 62, 0, 9, 0};
   int recv_pct_by_phase[NUM_PHASES] = '{0, 0, 62, 9, 0};

   initial begin
      int seg;
      int target;
      int p;
      seg = 0;

      // directed: field extremes, a fresh start on every kind of byte
      push_word(8'hFF, 1'b1);
      push_word(8'h00, 1'b1);
      push_word(8'h80, 1'b0);
      // lone cr restarts the terminator, then an empty header
      push_word(hrcc_pkg::CH_CR, 1'b1);
      push_word(hrcc_pkg::CH_CR, 1'b0);
      push_word(hrcc_pkg::CH_LF, 1'b0);
      push_crlf();
      // body with no framing header
      push_crlf();
      push_word(hrcc_pkg::CH_ZERO, 1'b0);
      push_crlf();
      // restart in the middle of a body
      push_word(hrcc_pkg::CH_CR, 1'b1);
      push_word(hrcc_pkg::CH_LF, 1'b0);
      push_crlf();
      push_word(8'hFF, 1'b0);
      push_word(8'h7F, 1'b0);
      // header that never finishes
      push_text("chunked", 1'b1);
      push_word(8'h01, 1'b0);

      while (pending_bytes.size() < TOTAL_WORDS) push_request();
      total_words = pending_bytes.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // idle phases rotate every segment of accepted words
      while (words_in < total_words) begin
         @(negedge clock);
         p = seg % NUM_PHASES;
         send_idle_pct  = send_pct_by_phase[p];
         recv_stall_pct = recv_pct_by_phase[p];
         if (p == PRESSURE_PHASE) hold_armed++;
         target = (seg + 1) * SEG_WORDS;
         while (words_in < target && words_in < total_words) @(negedge clock);
         seg++;
      end

      // everything sent; wait for the last results, then a quiet drain
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (pending_bytes.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (errors == 0 && expected_verdicts.size() == 0) begin
         $display("[http_request_completeness_check_unit] OK");
      end else begin
         $display("[http_request_completeness_check_unit] ERROR");
      end
      $finish;
   end

endmodule
